[design/svl_pkg.sv]
// ----------------------------------------------------------------------------
// svl_pkg
// Shared codes and control/status bundles of the sorted value list.
// ----------------------------------------------------------------------------
package svl_pkg;

  localparam int unsigned DataW = 32;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;

  // result status codes
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_EMPTY     = 2'd1;
  localparam logic [1:0] STS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STS_FULL      = 2'd3;

  // result data source
  typedef enum logic [1:0] {
    SEL_VALUE,
    SEL_HEAD,
    SEL_ZERO
  } emit_sel_e;

  typedef struct packed {
    logic       load;
    logic       ins;
    logic       rem;
    logic       rot;
    logic       emit;
    emit_sel_e  sel;
    logic [1:0] status;
    logic       last;
  } svl_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic found;
    logic dump_last;
  } svl_sts_t;

endpackage

[design/svl_dpath.sv]
// ----------------------------------------------------------------------------
// svl_dpath
// Chain of value cells with per-cell compare, shift insert/remove, rotating
// dump and the result register.
// ----------------------------------------------------------------------------
module svl_dpath #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  svl_pkg::svl_ctl_t             ctl_i,
  input  logic signed [svl_pkg::DataW-1:0] value_i,
  output svl_pkg::svl_sts_t             sts_o,
  output logic        [svl_pkg::DataW-1:0] out_data_o,
  output logic        [1:0]             out_status_o,
  output logic                          out_last_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic signed [svl_pkg::DataW-1:0] cell_q [CAPACITY];
  logic signed [svl_pkg::DataW-1:0] cell_d [CAPACITY];
  logic signed [svl_pkg::DataW-1:0] nxt    [CAPACITY];
  logic signed [svl_pkg::DataW-1:0] prv    [CAPACITY];
  logic signed [svl_pkg::DataW-1:0] value_q;

  logic [CW-1:0]       count_q, count_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [CAPACITY-1:0] lt_q, lt_d, eq_q, eq_d;
  logic [CAPACITY-1:0] ge, ge_prev, hit;

  logic [svl_pkg::DataW-1:0] out_data_q;
  logic [1:0]                out_status_q;
  logic                      out_last_q;

  // compare against the incoming value, only valid cells count
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt_d[i] = (CW'(i) < count_q) && (cell_q[i] < value_i);
      eq_d[i] = (CW'(i) < count_q) && (cell_q[i] == value_i);
    end
  end

  // neighbor views of the chain
  always_comb begin
    for (int i = 0; i < CAPACITY - 1; i++) begin
      nxt[i]     = cell_q[i+1];
      prv[i + 1] = cell_q[i];
    end
    nxt[CAPACITY-1] = cell_q[CAPACITY-1];
    prv[0]          = value_q;
  end

  always_comb begin
    logic acc;
    acc     = 1'b0;
    ge      = ~lt_q;
    ge_prev = {ge[CAPACITY-2:0], 1'b0};
    for (int i = 0; i < CAPACITY; i++) begin
      acc    = acc | eq_q[i];
      hit[i] = acc;
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_d[i] = cell_q[i];
      if (ctl_i.ins) begin
        if (ge[i] && !ge_prev[i]) begin
          cell_d[i] = value_q;
        end else if (ge_prev[i]) begin
          cell_d[i] = prv[i];
        end
      end else if (ctl_i.rem) begin
        if (hit[i]) begin
          cell_d[i] = nxt[i];
        end
      end else if (ctl_i.rot) begin
        if (CW'(i + 1) == count_q) begin
          cell_d[i] = cell_q[0];
        end else begin
          cell_d[i] = nxt[i];
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctl_i.ins) begin
      count_d = count_q + CW'(1);
    end else if (ctl_i.rem) begin
      count_d = count_q - CW'(1);
    end
    idx_d = idx_q;
    if (ctl_i.load) begin
      idx_d = '0;
    end else if (ctl_i.rot) begin
      idx_d = idx_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_q[i] <= cell_d[i];
    end
    if (ctl_i.load) begin
      value_q <= value_i;
      lt_q    <= lt_d;
      eq_q    <= eq_d;
    end
    if (ctl_i.emit) begin
      case (ctl_i.sel)
        svl_pkg::SEL_VALUE: out_data_q <= value_q;
        svl_pkg::SEL_HEAD:  out_data_q <= cell_q[0];
        svl_pkg::SEL_ZERO:  out_data_q <= '0;
        default:            out_data_q <= '0;
      endcase
      out_status_q <= ctl_i.status;
      out_last_q   <= ctl_i.last;
    end
  end

  assign sts_o.full      = (count_q == CW'(CAPACITY));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.found     = hit[CAPACITY-1];
  assign sts_o.dump_last = ((CW'(idx_q) + CW'(1)) == count_q);

  assign out_data_o   = out_data_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

endmodule

[design/svl_ctrl.sv]
// ----------------------------------------------------------------------------
// svl_ctrl
// Command sequencer: takes a command, runs the list update or the dump and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module svl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [1:0]            in_cmd_i,
  output logic                  in_ready_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  input  svl_pkg::svl_sts_t     sts_i,
  output svl_pkg::svl_ctl_t     ctl_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_e;

  state_e     state_q;
  logic [1:0] cmd_q;
  logic       valid_q;
  logic       out_free;

  assign out_free    = !valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = valid_q;

  always_comb begin
    ctl_o        = '0;
    ctl_o.sel    = svl_pkg::SEL_VALUE;
    ctl_o.status = svl_pkg::STS_OK;
    ctl_o.load   = (state_q == S_IDLE) && in_valid_i;
    case (state_q)
      S_EXEC: begin
        if (out_free) begin
          case (cmd_q)
            svl_pkg::CMD_INSERT: begin
              ctl_o.emit   = 1'b1;
              ctl_o.last   = 1'b1;
              ctl_o.ins    = !sts_i.full;
              ctl_o.status = sts_i.full ? svl_pkg::STS_FULL : svl_pkg::STS_OK;
            end
            svl_pkg::CMD_REMOVE: begin
              ctl_o.emit = 1'b1;
              ctl_o.last = 1'b1;
              ctl_o.rem  = !sts_i.empty && sts_i.found;
              if (sts_i.empty) begin
                ctl_o.status = svl_pkg::STS_EMPTY;
              end else if (!sts_i.found) begin
                ctl_o.status = svl_pkg::STS_NOT_FOUND;
              end
            end
            svl_pkg::CMD_DUMP: begin
              if (sts_i.empty) begin
                ctl_o.emit   = 1'b1;
                ctl_o.last   = 1'b1;
                ctl_o.sel    = svl_pkg::SEL_ZERO;
                ctl_o.status = svl_pkg::STS_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          ctl_o.emit = 1'b1;
          ctl_o.rot  = 1'b1;
          ctl_o.sel  = svl_pkg::SEL_HEAD;
          ctl_o.last = sts_i.dump_last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= svl_pkg::CMD_INSERT;
      valid_q <= 1'b0;
    end else begin
      if (ctl_o.emit) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q   <= in_cmd_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            if (cmd_q == svl_pkg::CMD_DUMP && !sts_i.empty) begin
              state_q <= S_DUMP;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_DUMP: begin
          if (out_free && sts_i.dump_last) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[design/sorted_value_list.sv]
// insert and remove: the input transfer registers the value and the cell compare flags;
// the shift and the result register follow once the output is free, one command at a time
// a dump gives one result per cycle from the head while the output is free
// the input is taken again only after the current command has issued its last result
// reset clears the entry count and the sequencer; cell contents stay undefined until written
// ----------------------------------------------------------------------------
// sorted_value_list
// Bounded ascending list of signed values with insert, remove and dump commands.
// ----------------------------------------------------------------------------
module sorted_value_list #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] item_value
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast
);

  svl_pkg::svl_ctl_t ctl;
  svl_pkg::svl_sts_t sts;

  svl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  svl_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .value_i      (s_axis_tdata),
    .sts_o        (sts),
    .out_data_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

  a_one_cmd_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a command is in progress");

  a_non_last_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == svl_pkg::STS_OK))
    else $error("non-final result with error status");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == svl_pkg::STS_EMPTY) |-> m_axis_tlast)
    else $error("empty status not on final result");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.full |-> !sts.empty)
    else $error("list both full and empty");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted value list. A driver sends insert,
// remove, dump and unused commands from a queue, a shadow list predicts every
// result, and a monitor checks value, status and tlast of each output
// transfer. Both sides stall in random bursts, with one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned LIST_CAPACITY = 32;
  localparam logic [1:0]  CMD_UNUSED    = 2'd3;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          HOLD_AT       = 150;
  localparam int          CALM_TAIL     = 50;
  localparam int          RANDOM_ITEMS  = 400;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
  } command_t;

  typedef struct packed {
    logic signed [31:0] item_value;
    logic [1:0]         status;
    logic               last;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  command_t           command_queue[$];
  outcome_t           awaited_outcomes[$];
  logic signed [31:0] sorted_shadow[$];
  logic signed [31:0] value_pool[12];

  int total_commands;
  int commands_sent;
  int results_checked;
  int mismatches;
  int inserts_done, full_refusals, removes_hit, removes_missed, removes_empty;
  int dumps_done, peak_size;
  int send_gap, recv_gap, hold_left, stall_cycles;
  bit hold_done;
  command_t next_command;
  outcome_t oldest;

  sorted_value_list #(
    .CAPACITY(LIST_CAPACITY)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void push_outcome(logic signed [31:0] v, logic [1:0] st, logic lst);
    outcome_t o;
    o.item_value = v;
    o.status     = st;
    o.last       = lst;
    awaited_outcomes.push_back(o);
  endfunction

  function automatic void apply_command(logic [1:0] cmd, logic signed [31:0] value);
    int pos;
    int n;
    pos = 0;
    n   = sorted_shadow.size();
    case (cmd)
      svl_pkg::CMD_INSERT: begin
        if (n >= LIST_CAPACITY) begin
          push_outcome(value, svl_pkg::STS_FULL, 1'b1);
          full_refusals++;
        end else begin
          while (pos < n && sorted_shadow[pos] < value) pos++;
          sorted_shadow.insert(pos, value);
          push_outcome(value, svl_pkg::STS_OK, 1'b1);
          inserts_done++;
          if (n + 1 > peak_size) peak_size = n + 1;
        end
      end
      svl_pkg::CMD_REMOVE: begin
        if (n == 0) begin
          push_outcome(value, svl_pkg::STS_EMPTY, 1'b1);
          removes_empty++;
        end else begin
          while (pos < n && sorted_shadow[pos] != value) pos++;
          if (pos == n) begin
            push_outcome(value, svl_pkg::STS_NOT_FOUND, 1'b1);
            removes_missed++;
          end else begin
            sorted_shadow.delete(pos);
            push_outcome(value, svl_pkg::STS_OK, 1'b1);
            removes_hit++;
          end
        end
      end
      svl_pkg::CMD_DUMP: begin
        dumps_done++;
        if (n == 0) begin
          push_outcome('0, svl_pkg::STS_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            push_outcome(sorted_shadow[i], svl_pkg::STS_OK, (i == n - 1));
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void add_command(logic [1:0] cmd, logic signed [31:0] value);
    command_t c;
    c.cmd   = cmd;
    c.value = value;
    command_queue.push_back(c);
  endfunction

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 99) < 65) return value_pool[$urandom_range(0, 11)];
    return $urandom;
  endfunction

  function automatic void build_stimulus();
    int mode;
    int len;
    int r;
    int ins_pct;
    int rem_pct;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7FFF_FFFF;
    value_pool[2] = 0;
    value_pool[3] = -1;
    value_pool[4] = 1;
    for (int i = 5; i < 12; i++) value_pool[i] = $urandom;

    // directed: empty list cases, extremes, duplicates, miss, unused code
    add_command(svl_pkg::CMD_DUMP, 32'sh1234_5678);
    add_command(svl_pkg::CMD_REMOVE, 5);
    add_command(svl_pkg::CMD_INSERT, 32'sh8000_0000);
    add_command(svl_pkg::CMD_INSERT, 32'sh7FFF_FFFF);
    add_command(svl_pkg::CMD_INSERT, 0);
    add_command(svl_pkg::CMD_INSERT, -1);
    add_command(svl_pkg::CMD_INSERT, 0);
    add_command(svl_pkg::CMD_INSERT, 32'sh5555_5555);
    add_command(svl_pkg::CMD_INSERT, 32'shAAAA_AAAA);
    add_command(svl_pkg::CMD_DUMP, -1);
    add_command(svl_pkg::CMD_REMOVE, 12345);
    add_command(svl_pkg::CMD_REMOVE, 0);
    add_command(svl_pkg::CMD_REMOVE, 32'sh7FFF_FFFF);
    add_command(CMD_UNUSED, 32'shFFFF_FFFF);
    add_command(svl_pkg::CMD_DUMP, 0);
    add_command(svl_pkg::CMD_REMOVE, 32'sh8000_0000);
    add_command(svl_pkg::CMD_REMOVE, -1);
    add_command(svl_pkg::CMD_REMOVE, 0);
    add_command(svl_pkg::CMD_REMOVE, 32'sh5555_5555);
    add_command(svl_pkg::CMD_REMOVE, 32'shAAAA_AAAA);
    add_command(svl_pkg::CMD_REMOVE, 32'shAAAA_AAAA);
    add_command(svl_pkg::CMD_DUMP, 32'sh5A5A_A5A5);

    // fill to capacity and beyond
    for (int i = 0; i < LIST_CAPACITY + 3; i++) add_command(svl_pkg::CMD_INSERT, pick_value());
    add_command(svl_pkg::CMD_DUMP, $urandom);

    // random phases: filling, draining, mixed
    while (command_queue.size() < RANDOM_ITEMS + 25) begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(20, 60);
      ins_pct = (mode == 0) ? 78 : (mode == 1) ? 15 : 45;
      rem_pct = (mode == 0) ? 10 : (mode == 1) ? 73 : 43;
      for (int i = 0; i < len && command_queue.size() < RANDOM_ITEMS + 25; i++) begin
        r = $urandom_range(0, 99);
        if (r < ins_pct) add_command(svl_pkg::CMD_INSERT, pick_value());
        else if (r < ins_pct + rem_pct) add_command(svl_pkg::CMD_REMOVE, pick_value());
        else if (r < 98) add_command(svl_pkg::CMD_DUMP, $urandom);
        else add_command(CMD_UNUSED, $urandom);
      end
    end
    add_command(svl_pkg::CMD_DUMP, $urandom);
    total_commands = command_queue.size();
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_command(s_axis_tuser, s_axis_tdata);
        commands_sent <= commands_sent + 1;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        s_axis_tvalid <= 1'b1;
      end else if (send_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap      <= send_gap - 1;
      end else if (command_queue.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (commands_sent < total_commands - CALM_TAIL && (commands_sent / 40) % 3 != 2
                   && $urandom_range(0, 5) == 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap      <= $urandom_range(0, 12);
      end else begin
        next_command  = command_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= next_command.cmd;
        s_axis_tdata  <= next_command.value;
      end
    end
  end

  // receiver ready, with one long hold-off to back up the input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap      <= 0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else if (!hold_done && commands_sent >= HOLD_AT) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (recv_gap != 0) begin
      m_axis_tready <= 1'b0;
      recv_gap      <= recv_gap - 1;
    end else if (commands_sent < total_commands - CALM_TAIL && (results_checked / 60) % 3 != 1
                 && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      recv_gap      <= $urandom_range(0, 12);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_outcomes.size() == 0) begin
        $error("unexpected result: value %0d status %0d tlast %0b",
               $signed(m_axis_tdata), m_axis_tuser, m_axis_tlast);
        mismatches++;
      end else begin
        oldest = awaited_outcomes.pop_front();
        if (m_axis_tdata !== oldest.item_value) begin
          $error("item_value: expected %0d, actual %0d", oldest.item_value,
                 $signed(m_axis_tdata));
          mismatches++;
        end
        if (m_axis_tuser !== oldest.status) begin
          $error("status: expected %0d, actual %0d", oldest.status, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tlast !== oldest.last) begin
          $error("last: expected %0b, actual %0b", oldest.last, m_axis_tlast);
          mismatches++;
        end
      end
      results_checked++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("** sorted_value_list: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    build_stimulus();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (command_queue.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (awaited_outcomes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("%0d commands, %0d results checked; %0d inserts, %0d refused as full, peak size %0d",
             commands_sent, results_checked, inserts_done, full_refusals, peak_size);
    $display("removes: %0d hit, %0d not found, %0d on empty list; %0d dumps; %0d mismatches",
             removes_hit, removes_missed, removes_empty, dumps_done, mismatches);
    if (mismatches == 0) begin
      $display("** sorted_value_list: PASSED **");
    end else begin
      $display("** sorted_value_list: FAILED **");
    end
    $finish;
  end

endmodule
